/* sv/ssd_pkg.sv */
package ssd_pkg;

   localparam int DIGIT_COUNT = 8;
   localparam int DIGIT_BITS  = $clog2(DIGIT_COUNT);

   // Stages from the input register up to the digit register that feeds the buffer.
   localparam int PIPE_DEPTH = 8;

   localparam logic [7:0] SEG_BLANK = 8'h00;
   localparam logic [7:0] SEG_MINUS = 8'h40;
   localparam logic [7:0] SEG_C     = 8'h58;
   localparam logic [7:0] SEG_DP    = 8'h80;

   typedef enum logic [1:0] {
      MODE_SCAN  = 2'd0,
      MODE_CHAR  = 2'd1,
      MODE_INT   = 2'd2,
      MODE_FIXED = 2'd3
   } mode_type;

   // Per-transaction control fields that ride along the conversion pipeline.
   typedef struct packed {
      mode_type   mode;
      logic [3:0] position;
      logic [7:0] character;
      logic       negative;
   } ctl_type;

   // Decimal digits of the magnitude split as hi = mag / 1000, lo = mag % 1000.
   typedef struct packed {
      logic       valid;
      ctl_type    ctl;
      logic [3:0] hi_hundreds;
      logic [3:0] hi_tens;
      logic [3:0] hi_ones;
      logic [3:0] lo_hundreds;
      logic [3:0] lo_tens;
      logic [3:0] lo_ones;
   } digits_type;

endpackage

/* sv/seven_segment_display_controller_top.sv */
// Channel   | Handshake              | Payload
// ----------+------------------------+---------------------------------------------
// request   | start & !busy          | req_mode, req_position, req_character,
//           |                        | req_value
// response  | rsp_strobe (one cycle) | rsp_digit_select, rsp_segments
//
// One transaction is taken every cycle; busy stays low.
// A scan transaction raises rsp_strobe when it leaves the result register:
// eight pipeline register stages carry the decimal conversion (input,
// sign/magnitude, split by 1000, remainder, four digit stages), and the
// result register follows the segment buffer.
// Writes update the buffer at the same point, so scans and writes keep order.
// reset is synchronous, active high: it clears the buffer and all valids.
// The receiver cannot stall; each strobe lasts exactly one cycle.
module seven_segment_display_controller_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [3:0]         req_position,
   input  logic [7:0]         req_character,
   input  logic signed [25:0] req_value,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_digit_select,
   output logic [7:0]         rsp_segments
);
   import ssd_pkg::*;

   digits_type digits;
   logic       req_accept;

   // fully pipelined, never holds off a request
   assign busy       = 1'b0;
   assign req_accept = start & ~busy;

   // sign/magnitude, split by 1000, then digit extraction by tens
   ssd_conv u_conv (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req_mode      (req_mode),
      .req_position  (req_position),
      .req_character (req_character),
      .req_value     (req_value),
      .digits        (digits)
   );

   // segment buffer, character encoding, scan read and response register
   ssd_disp u_disp (
      .clock            (clock),
      .reset            (reset),
      .digits           (digits),
      .rsp_strobe       (rsp_strobe),
      .rsp_digit_select (rsp_digit_select),
      .rsp_segments     (rsp_segments)
   );

endmodule

/* sv/ssd_conv.sv */
module ssd_conv (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  logic [1:0]          req_mode,
   input  logic [3:0]          req_position,
   input  logic [7:0]          req_character,
   input  logic signed [25:0]  req_value,
   output ssd_pkg::digits_type digits
);
   import ssd_pkg::*;

   // floor(x / d) = (x * m) >> k, exact over the full input width
   localparam logic [26:0] RECIP_1000   = 27'd68719477;  // k = 36, 26-bit input
   localparam logic [25:0] K1000        = 26'd1000;
   localparam logic [16:0] RECIP_10_HI  = 17'd104858;    // k = 20, 16-bit input
   localparam logic [10:0] RECIP_10_LO  = 11'd1639;      // k = 14, 10-bit input
   localparam logic [12:0] RECIP_10_A   = 13'd6554;      // k = 16, 12-bit input
   localparam logic [7:0]  RECIP_10_B   = 8'd205;        // k = 11, 7-bit input
   localparam logic [9:0]  RECIP_10_A2  = 10'd820;       // k = 13, 9-bit input

   // x - 10*q, known to be 0..9, so mod-16 arithmetic is exact
   function automatic logic [3:0] rem10(input logic [3:0] x, input logic [3:0] q);
      logic [3:0] t;
      t = q * 4'd10;
      return x - t;
   endfunction

   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   ctl_type               ctl_ff [PIPE_DEPTH];
   ctl_type               ctl_in [PIPE_DEPTH];

   // stage 0: input register
   logic [25:0] value_ff, value_in;
   // stage 1: sign and magnitude
   logic [25:0] mag1_ff, mag1_in;
   logic        neg1;
   // stage 2: integer part (mag / 1000)
   logic [52:0] prod_hi;
   logic [25:0] mag2_ff, mag2_in;
   logic [15:0] hi2_ff, hi2_in;
   // stage 3: fraction (mag % 1000)
   logic [25:0] hi_x1000;
   logic [15:0] hi3_ff, hi3_in;
   logic [9:0]  lo3_ff, lo3_in;
   // stage 4: first division by ten
   logic [32:0] prod_a;
   logic [20:0] prod_b;
   logic [15:0] hi4_ff, hi4_in;
   logic [9:0]  lo4_ff, lo4_in;
   logic [11:0] a4_ff, a4_in;
   logic [6:0]  b4_ff, b4_in;
   // stage 5: ones digits, second division
   logic [24:0] prod_a2;
   logic [14:0] prod_c;
   logic [3:0]  h0_5_ff, h0_5_in, l0_5_ff, l0_5_in, l2_5_ff, l2_5_in;
   logic [11:0] a5_ff, a5_in;
   logic [6:0]  b5_ff, b5_in;
   logic [8:0]  a2_5_ff, a2_5_in;
   // stage 6: tens digits, third division
   logic [18:0] prod_a3;
   logic [3:0]  h0_6_ff, h0_6_in, l0_6_ff, l0_6_in, l2_6_ff, l2_6_in;
   logic [3:0]  h1_6_ff, h1_6_in, l1_6_ff, l1_6_in;
   logic [8:0]  a2_6_ff, a2_6_in;
   logic [5:0]  a3_6_ff, a3_6_in;
   // stage 7: hundreds digit of the integer part
   logic [3:0]  h0_7_ff, h0_7_in, h1_7_ff, h1_7_in, h2_7_ff, h2_7_in;
   logic [3:0]  l0_7_ff, l0_7_in, l1_7_ff, l1_7_in, l2_7_ff, l2_7_in;

   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_accept};

   always_comb begin
      ctl_in[0].mode      = mode_type'(req_mode);
      ctl_in[0].position  = req_position;
      ctl_in[0].character = req_character;
      ctl_in[0].negative  = 1'b0;
      ctl_in[1]           = ctl_ff[0];
      ctl_in[1].negative  = neg1;
      for (int i = 2; i < PIPE_DEPTH; i++) begin
         ctl_in[i] = ctl_ff[i-1];
      end
   end

   assign value_in = $unsigned(req_value);

   // integer mode looks at the low 16 bits only
   always_comb begin
      if (ctl_ff[0].mode == MODE_INT) begin
         neg1    = value_ff[15];
         mag1_in = {10'd0, (value_ff[15] ? (16'd0 - value_ff[15:0]) : value_ff[15:0])};
      end else begin
         neg1    = value_ff[25];
         mag1_in = value_ff[25] ? (26'd0 - value_ff) : value_ff;
      end
   end

   assign prod_hi = 53'(mag1_ff) * 53'(RECIP_1000);
   assign hi2_in  = prod_hi[51:36];
   assign mag2_in = mag1_ff;

   assign hi_x1000 = 26'(hi2_ff) * K1000;
   assign lo3_in   = 10'(mag2_ff - hi_x1000);
   assign hi3_in   = hi2_ff;

   assign prod_a = 33'(hi3_ff) * 33'(RECIP_10_HI);
   assign prod_b = 21'(lo3_ff) * 21'(RECIP_10_LO);
   assign a4_in  = prod_a[31:20];
   assign b4_in  = prod_b[20:14];
   assign hi4_in = hi3_ff;
   assign lo4_in = lo3_ff;

   assign prod_a2 = 25'(a4_ff) * 25'(RECIP_10_A);
   assign prod_c  = 15'(b4_ff) * 15'(RECIP_10_B);
   assign a2_5_in = prod_a2[24:16];
   assign l2_5_in = prod_c[14:11];
   assign h0_5_in = rem10(hi4_ff[3:0], a4_ff[3:0]);
   assign l0_5_in = rem10(lo4_ff[3:0], b4_ff[3:0]);
   assign a5_in   = a4_ff;
   assign b5_in   = b4_ff;

   assign prod_a3 = 19'(a2_5_ff) * 19'(RECIP_10_A2);
   assign a3_6_in = prod_a3[18:13];
   assign h1_6_in = rem10(a5_ff[3:0], a2_5_ff[3:0]);
   assign l1_6_in = rem10(b5_ff[3:0], l2_5_ff);
   assign h0_6_in = h0_5_ff;
   assign l0_6_in = l0_5_ff;
   assign l2_6_in = l2_5_ff;
   assign a2_6_in = a2_5_ff;

   assign h2_7_in = rem10(a2_6_ff[3:0], a3_6_ff[3:0]);
   assign h1_7_in = h1_6_ff;
   assign h0_7_in = h0_6_ff;
   assign l2_7_in = l2_6_ff;
   assign l1_7_in = l1_6_ff;
   assign l0_7_in = l0_6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
         ctl_ff[i] <= ctl_in[i];
      end
      value_ff <= value_in;
      mag1_ff  <= mag1_in;
      mag2_ff  <= mag2_in;
      hi2_ff   <= hi2_in;
      hi3_ff   <= hi3_in;
      lo3_ff   <= lo3_in;
      hi4_ff   <= hi4_in;
      lo4_ff   <= lo4_in;
      a4_ff    <= a4_in;
      b4_ff    <= b4_in;
      h0_5_ff  <= h0_5_in;
      l0_5_ff  <= l0_5_in;
      l2_5_ff  <= l2_5_in;
      a5_ff    <= a5_in;
      b5_ff    <= b5_in;
      a2_5_ff  <= a2_5_in;
      h0_6_ff  <= h0_6_in;
      l0_6_ff  <= l0_6_in;
      l2_6_ff  <= l2_6_in;
      h1_6_ff  <= h1_6_in;
      l1_6_ff  <= l1_6_in;
      a2_6_ff  <= a2_6_in;
      a3_6_ff  <= a3_6_in;
      h0_7_ff  <= h0_7_in;
      h1_7_ff  <= h1_7_in;
      h2_7_ff  <= h2_7_in;
      l0_7_ff  <= l0_7_in;
      l1_7_ff  <= l1_7_in;
      l2_7_ff  <= l2_7_in;
   end

   assign digits.valid       = vld_ff[PIPE_DEPTH-1];
   assign digits.ctl         = ctl_ff[PIPE_DEPTH-1];
   assign digits.hi_hundreds = h2_7_ff;
   assign digits.hi_tens     = h1_7_ff;
   assign digits.hi_ones     = h0_7_ff;
   assign digits.lo_hundreds = l2_7_ff;
   assign digits.lo_tens     = l1_7_ff;
   assign digits.lo_ones     = l0_7_ff;

endmodule

/* sv/ssd_disp.sv */
module ssd_disp (
   input  logic                clock,
   input  logic                reset,
   input  ssd_pkg::digits_type digits,
   output logic                rsp_strobe,
   output logic [7:0]          rsp_digit_select,
   output logic [7:0]          rsp_segments
);
   import ssd_pkg::*;

   function automatic logic [7:0] digit_code(input logic [3:0] d);
      logic [7:0] c;
      unique case (d)
         4'd0:    c = 8'h3F;
         4'd1:    c = 8'h06;
         4'd2:    c = 8'h5B;
         4'd3:    c = 8'h4F;
         4'd4:    c = 8'h66;
         4'd5:    c = 8'h6D;
         4'd6:    c = 8'h7D;
         4'd7:    c = 8'h07;
         4'd8:    c = 8'h7F;
         4'd9:    c = 8'h6F;
         default: c = SEG_BLANK;
      endcase
      return c;
   endfunction

   // {known, code}
   function automatic logic [8:0] char_code(input logic [7:0] ch);
      logic [8:0] r;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         r = {1'b1, digit_code(4'(ch - 8'h30))};
      end else begin
         unique case (ch)
            8'h20:   r = {1'b1, SEG_BLANK};
            8'h71:   r = {1'b1, 8'h67};  // q
            8'h64:   r = {1'b1, 8'h5E};  // d
            8'h63:   r = {1'b1, SEG_C};  // c
            8'h48:   r = {1'b1, 8'h76};  // H
            8'h4C:   r = {1'b1, 8'h38};  // L
            8'h50:   r = {1'b1, 8'h73};  // P
            default: r = {1'b0, SEG_BLANK};
         endcase
      end
      return r;
   endfunction

   logic [7:0]            seg_buf_ff [DIGIT_COUNT];
   logic [7:0]            seg_buf_in [DIGIT_COUNT];
   logic                  strobe_ff, strobe_in;
   logic [7:0]            dsel_ff, dsel_in;
   logic [7:0]            seg_ff, seg_in;
   logic [DIGIT_BITS-1:0] scan_pos;
   logic [DIGIT_BITS-1:0] wr_pos;
   logic [8:0]            enc;
   logic [7:0]            sign_code;

   assign scan_pos  = digits.ctl.position[3] ? DIGIT_BITS'(DIGIT_COUNT - 1)
                                             : digits.ctl.position[DIGIT_BITS-1:0];
   assign wr_pos    = digits.ctl.position[DIGIT_BITS-1:0];
   assign enc       = char_code(digits.ctl.character);
   assign sign_code = digits.ctl.negative ? SEG_MINUS : SEG_BLANK;

   always_comb begin
      seg_buf_in = seg_buf_ff;
      strobe_in  = 1'b0;
      dsel_in    = dsel_ff;
      seg_in     = seg_ff;
      if (digits.valid) begin
         unique case (digits.ctl.mode)
            MODE_SCAN: begin
               strobe_in = 1'b1;
               dsel_in   = ~(8'h01 << scan_pos);
               seg_in    = seg_buf_ff[scan_pos];
            end
            MODE_CHAR: begin
               if (!digits.ctl.position[3] && enc[8]) begin
                  seg_buf_in[wr_pos] = enc[7:0];
               end
            end
            MODE_INT: begin
               // hi = mag / 1000 is at most 32 here
               seg_buf_in[0] = sign_code;
               seg_buf_in[1] = digit_code(digits.hi_tens);
               seg_buf_in[2] = digit_code(digits.hi_ones);
               seg_buf_in[3] = digit_code(digits.lo_hundreds);
               seg_buf_in[4] = digit_code(digits.lo_tens);
               seg_buf_in[5] = digit_code(digits.lo_ones);
            end
            MODE_FIXED: begin
               seg_buf_in[0] = sign_code;
               seg_buf_in[1] = digit_code(digits.hi_hundreds);
               seg_buf_in[2] = digit_code(digits.hi_tens);
               seg_buf_in[3] = digit_code(digits.hi_ones) | SEG_DP;
               seg_buf_in[4] = digit_code(digits.lo_hundreds);
               seg_buf_in[5] = digit_code(digits.lo_tens);
               seg_buf_in[6] = digit_code(digits.lo_ones);
               seg_buf_in[7] = SEG_C;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            seg_buf_ff[i] <= SEG_BLANK;
         end
         strobe_ff <= 1'b0;
      end else begin
         seg_buf_ff <= seg_buf_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      dsel_ff <= dsel_in;
      seg_ff  <= seg_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_digit_select = dsel_ff;
   assign rsp_segments     = seg_ff;

endmodule

/* sv/ssd_chk.sv */
module ssd_chk (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [1:0]         req_mode,
   input logic [3:0]         req_position,
   input logic               rsp_strobe,
   input logic [7:0]         rsp_digit_select
);
   import ssd_pkg::*;

   localparam int LAT = PIPE_DEPTH + 1;

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy asserted");

   a_one_digit : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $onehot(~rsp_digit_select))
      else $error("digit select not one-hot low");

   a_from_scan : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && (req_mode == MODE_SCAN), LAT))
      else $error("response without a scan transaction");

   a_scan_digit : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_digit_select ==
         (($past(req_position, LAT) > 4'd7) ? 8'h7F
                                             : ~(8'h01 << $past(req_position, LAT)))))
      else $error("wrong digit selected");

endmodule

bind seven_segment_display_controller_top ssd_chk u_chk (.*);
